[design/bpg_pkg.sv]
package bpg_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned HALF_W   = 4;
    localparam int unsigned DONE_W   = 12;
    localparam int unsigned PHASE_W  = 5;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_SHORT = 3'd1;
    localparam logic [OP_W-1:0] OP_LONG  = 3'd2;
    localparam logic [OP_W-1:0] OP_CONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_OFF   = 3'd4;

    localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHORT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LONG  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CONT  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_HALF = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HALF  = 1'd1;

    localparam logic [HALF_W-1:0] SHORT_HALF_RST = 4'd2;
    localparam logic [HALF_W-1:0] LONG_HALF_RST  = 4'd5;

endpackage

[design/bpg_in_if.sv]
interface bpg_in_if import bpg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [COUNT_W-1:0]  beep_count;

    modport source (output valid, output operation, output beep_count, input ready);
    modport sink   (input valid, input operation, input beep_count, output ready);
endinterface

[design/bpg_out_if.sv]
interface bpg_out_if import bpg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               drive_on;
    logic [MODE_W-1:0]  active_mode;

    modport source (output valid, output drive_on, output active_mode, input ready);
    modport sink   (input valid, input drive_on, input active_mode, output ready);
endinterface

[design/beep_pattern_generator.sv]
// channel   dir  handshake     payload
// i_in      in   valid/ready   operation[2:0], beep_count[7:0]
// o_out     out  valid/ready   drive_on, active_mode[1:0]
// i_cfg_*   in   write enable  index[0], data[3:0]
//
// one item per cycle while o_out is not stalled; each item is folded into the state
// registers at its transfer and its result is shown the next cycle from those registers
// the single result slot sets the rate: a new item is taken whenever the
// slot is empty or its result leaves in the same cycle
// synchronous active-low reset clears the mode state and loads the default half periods
module beep_pattern_generator import bpg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bpg_in_if.sink                i_in,
    bpg_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [HALF_W-1:0]     i_cfg_data
);

    logic [HALF_W-1:0]   r_short_half;
    logic [HALF_W-1:0]   r_long_half;
    logic [MODE_W-1:0]   r_mode,    n_mode;
    logic [MODE_W-1:0]   r_pending, n_pending;
    logic [COUNT_W-1:0]  r_target,  n_target;
    logic [DONE_W-1:0]   r_done,    n_done;
    logic [PHASE_W-1:0]  r_phase,   n_phase;
    logic                r_pin,     n_pin;
    logic                r_out_valid;

    logic                in_fire;
    logic [HALF_W-1:0]   half;
    logic [DONE_W-1:0]   goal;
    logic [DONE_W-1:0]   done_step;
    logic [PHASE_W-1:0]  phase_inc;
    logic [PHASE_W-1:0]  phase_step;
    logic                on_phase;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;

    // state only moves on a transfer, so the result can be read straight off it
    assign o_out.valid       = r_out_valid;
    assign o_out.drive_on    = r_pin;
    assign o_out.active_mode = r_mode;

    assign half       = (r_mode == MODE_SHORT) ? r_short_half : r_long_half;
    assign goal       = DONE_W'(r_target) * DONE_W'(half);
    assign on_phase   = r_phase < PHASE_W'(half);
    assign done_step  = on_phase ? r_done : r_done + DONE_W'(1);
    assign phase_inc  = r_phase + PHASE_W'(1);
    assign phase_step = (phase_inc >= {half, 1'b0}) ? '0 : phase_inc;

    always_comb begin
        n_mode    = r_mode;
        n_pending = r_pending;
        n_target  = r_target;
        n_done    = r_done;
        n_phase   = r_phase;
        n_pin     = r_pin;
        case (i_in.operation)
            OP_TICK: begin
                if (r_mode == MODE_IDLE) begin
                    if (r_pending == MODE_IDLE) begin
                        n_pin = 1'b0;
                    end else begin
                        n_mode  = r_pending;
                        n_phase = '0;
                        n_done  = '0;
                    end
                end else if (r_pending != r_mode) begin
                    n_pin   = 1'b0;
                    n_phase = '0;
                    n_done  = '0;
                    n_mode  = r_pending;
                end else if (r_mode == MODE_CONT) begin
                    n_pin = 1'b1;
                end else begin
                    n_pin   = on_phase;
                    n_done  = done_step;
                    n_phase = phase_step;
                    // run complete: drop back to idle on the next tick
                    if (done_step == goal) begin
                        n_pending = MODE_IDLE;
                        n_done    = '0;
                        n_phase   = '0;
                        n_target  = '0;
                    end
                end
            end
            OP_SHORT: begin
                n_target  = i_in.beep_count;
                n_done    = '0;
                n_pending = MODE_SHORT;
            end
            OP_LONG: begin
                n_target  = i_in.beep_count;
                n_done    = '0;
                n_pending = MODE_LONG;
            end
            OP_CONT: begin
                n_pending = MODE_CONT;
            end
            OP_OFF: begin
                n_pending = MODE_IDLE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_half <= SHORT_HALF_RST;
            r_long_half  <= LONG_HALF_RST;
            r_mode       <= MODE_IDLE;
            r_pending    <= MODE_IDLE;
            r_target     <= '0;
            r_done       <= '0;
            r_phase      <= '0;
            r_pin        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SHORT_HALF: r_short_half <= i_cfg_data;
                    REG_LONG_HALF:  r_long_half  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (in_fire) begin
                r_mode    <= n_mode;
                r_pending <= n_pending;
                r_target  <= n_target;
                r_done    <= n_done;
                r_phase   <= n_phase;
                r_pin     <= n_pin;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_cmd_keeps_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in.operation != OP_TICK |=> r_mode == $past(r_mode))
        else $error("command transfer changed the current mode");

    a_leave_silences: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in.operation == OP_TICK && r_mode != MODE_IDLE
        && r_pending != r_mode |=> !r_pin)
        else $error("leaving a mode left the drive on");

    a_cont_sounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in.operation == OP_TICK && r_mode == MODE_CONT
        && r_pending == MODE_CONT |=> r_pin)
        else $error("continuous mode tick did not sound the drive");

    a_idle_phase_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_IDLE |-> r_phase == '0)
        else $error("phase not cleared while idle");

    a_result_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_out.valid)
        else $error("transfer produced no result");
`endif

endmodule
